// File: design/scvs_pkg.sv
// Shared types and constants of the sparse chunked voxel store.
// Holds request and status codes, controller states and the result record.
// Depends on nothing.
package scvs_pkg;

	localparam int GRID_EDGE_DEF  = 128;
	localparam int CHUNK_EDGE_DEF = 16;
	localparam int POOL_SLOTS_DEF = 64;

	localparam int COORD_W = 11;
	localparam int BLOCK_W = 8;
	localparam int LIGHT_W = 4;
	localparam int WORD_W  = BLOCK_W + LIGHT_W;

	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W     = RECIP_SHIFT + 1;

	typedef enum logic [2:0] {
		REQ_RD_BLOCK = 3'd0,
		REQ_WR_BLOCK = 3'd1,
		REQ_RD_LIGHT = 3'd2,
		REQ_WR_LIGHT = 3'd3,
		REQ_CLEAR    = 3'd4
	} scvs_req_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_OUTSIDE = 2'd1,
		STAT_FULL    = 2'd2
	} scvs_status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SPLIT,
		S_DIR,
		S_POOL,
		S_MOD,
		S_ZERO,
		S_CLEAR
	} scvs_state_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] read_value;
		logic               removed;
		logic               placed;
		scvs_status_t       status;
	} scvs_result_t;

endpackage

// File: design/sparse_chunked_voxel_store_core.sv
// Sparse chunked voxel store: reads one result per request, strobed by done for one cycle.
// Access to an allocated chunk runs S_SPLIT, S_DIR, S_POOL and S_MOD, busy until S_IDLE.
// Outside grid ends after S_DIR, unallocated read or no-op write after S_POOL, undefined code in S_IDLE.
// Allocation adds a pool zeroing sweep over every local address of the new slot.
// Clear world and reset both sweep the directory, one entry per cycle, with busy high.
// The receiver cannot stall; results go out from an output register. Uses scvs_pkg.
module sparse_chunked_voxel_store_core import scvs_pkg::*; #(
	parameter int GRID_EDGE  = GRID_EDGE_DEF,
	parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                req_type,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [BLOCK_W-1:0]        block_type,
	input  logic [LIGHT_W-1:0]        light_level,
	input  logic                      notify,
	output logic                      done,
	output logic [BLOCK_W-1:0]        read_value,
	output logic                      removed_event,
	output logic                      placed_event,
	output logic [1:0]                status
);

	localparam int CPE = (GRID_EDGE + CHUNK_EDGE - 1) / CHUNK_EDGE;
	localparam int CB  = (CPE > 1) ? $clog2(CPE) : 1;
	localparam int LB  = $clog2(CHUNK_EDGE);
	localparam int SB  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int DAW = 3 * CB;
	localparam int LAW = 3 * LB;
	localparam int PAW = SB + LAW;

	logic              addr_go;
	logic              in_grid;
	logic [DAW-1:0]    dir_idx;
	logic [LAW-1:0]    local_idx;
	logic              dir_we;
	logic [DAW-1:0]    dir_addr;
	logic [SB:0]       dir_wdata;
	logic [SB:0]       dir_rdata;
	logic              pool_we;
	logic [PAW-1:0]    pool_addr;
	logic [WORD_W-1:0] pool_wdata;
	logic [WORD_W-1:0] pool_rdata;
	scvs_result_t      res;

	scvs_addr #(
		.GRID_EDGE  (GRID_EDGE),
		.CHUNK_EDGE (CHUNK_EDGE)
	) u_addr (
		.clk       (clk),
		.go        (addr_go),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.in_grid   (in_grid),
		.dir_idx   (dir_idx),
		.local_idx (local_idx)
	);

	scvs_ram #(
		.AW (DAW),
		.DW (SB + 1)
	) u_dir (
		.clk   (clk),
		.we    (dir_we),
		.addr  (dir_addr),
		.wdata (dir_wdata),
		.rdata (dir_rdata)
	);

	scvs_ram #(
		.AW (PAW),
		.DW (WORD_W)
	) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.addr  (pool_addr),
		.wdata (pool_wdata),
		.rdata (pool_rdata)
	);

	scvs_ctrl #(
		.GRID_EDGE  (GRID_EDGE),
		.CHUNK_EDGE (CHUNK_EDGE),
		.POOL_SLOTS (POOL_SLOTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.block_type  (block_type),
		.light_level (light_level),
		.notify      (notify),
		.addr_go     (addr_go),
		.in_grid     (in_grid),
		.dir_idx     (dir_idx),
		.local_idx   (local_idx),
		.dir_we      (dir_we),
		.dir_addr    (dir_addr),
		.dir_wdata   (dir_wdata),
		.dir_rdata   (dir_rdata),
		.pool_we     (pool_we),
		.pool_addr   (pool_addr),
		.pool_wdata  (pool_wdata),
		.pool_rdata  (pool_rdata),
		.done        (done),
		.res         (res)
	);

	assign read_value    = res.read_value;
	assign removed_event = res.removed;
	assign placed_event  = res.placed;
	assign status        = res.status;

endmodule

// File: design/scvs_ram.sv
// Single-port synchronous memory with a registered read port.
// Used for the chunk directory and for the voxel pool; no dependencies.
module scvs_ram #(
	parameter int AW = 9,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/scvs_addr.sv
// Two-stage coordinate splitter: grid check, chunk index and local offset.
// Division by the chunk edge uses a reciprocal multiply; uses scvs_pkg.
module scvs_addr import scvs_pkg::*; #(
	parameter int GRID_EDGE  = GRID_EDGE_DEF,
	parameter int CHUNK_EDGE = CHUNK_EDGE_DEF
) (
	input  logic                      clk,
	input  logic                      go,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	output logic                      in_grid,
	output logic [3*((((GRID_EDGE + CHUNK_EDGE - 1) / CHUNK_EDGE) > 1) ?
		$clog2((GRID_EDGE + CHUNK_EDGE - 1) / CHUNK_EDGE) : 1)-1:0] dir_idx,
	output logic [3*$clog2(CHUNK_EDGE)-1:0] local_idx
);

	localparam int CPE   = (GRID_EDGE + CHUNK_EDGE - 1) / CHUNK_EDGE;
	localparam int CB    = (CPE > 1) ? $clog2(CPE) : 1;
	localparam int LB    = $clog2(CHUNK_EDGE);
	localparam int XB    = $clog2(GRID_EDGE);
	localparam int PW    = XB + RECIP_W;
	localparam int MW    = XB + 7;
	localparam int RECIP = ((1 << RECIP_SHIFT) + CHUNK_EDGE - 1) / CHUNK_EDGE;

	logic [2:0][COORD_W-1:0] pos_all;
	logic [2:0]              ok_c;
	logic [2:0][PW-1:0]      prod_c;
	logic [2:0][CB-1:0]      q_c;
	logic [2:0][MW-1:0]      r_c;

	logic               ok_s1;
	logic [2:0][XB-1:0] xv_s1;
	logic [2:0][CB-1:0] q_s1;

	logic                 in_grid_s2;
	logic [3*CB-1:0]      dir_idx_s2;
	logic [3*LB-1:0]      local_idx_s2;

	assign pos_all = {pos_x, pos_y, pos_z};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ok_c[i]   = !pos_all[i][COORD_W-1] && (pos_all[i] < COORD_W'(GRID_EDGE));
			prod_c[i] = PW'(pos_all[i][XB-1:0]) * PW'(RECIP);
			q_c[i]    = prod_c[i][RECIP_SHIFT +: CB];
			r_c[i]    = MW'(xv_s1[i]) - MW'(q_s1[i]) * MW'(CHUNK_EDGE);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			ok_s1 <= &ok_c;
			for (int i = 0; i < 3; i++) begin
				xv_s1[i] <= pos_all[i][XB-1:0];
				q_s1[i]  <= q_c[i];
			end
		end
		in_grid_s2   <= ok_s1;
		dir_idx_s2   <= {q_s1[2], q_s1[1], q_s1[0]};
		local_idx_s2 <= {r_c[2][LB-1:0], r_c[1][LB-1:0], r_c[0][LB-1:0]};
	end

	assign in_grid   = in_grid_s2;
	assign dir_idx   = dir_idx_s2;
	assign local_idx = local_idx_s2;

endmodule

// File: design/scvs_ctrl.sv
// Request sequencer: directory lookup, pool read-modify-write, slot allocation
// with zeroing sweep, and directory clearing. Uses scvs_pkg.
module scvs_ctrl import scvs_pkg::*; #(
	parameter int GRID_EDGE  = GRID_EDGE_DEF,
	parameter int CHUNK_EDGE = CHUNK_EDGE_DEF,
	parameter int POOL_SLOTS = POOL_SLOTS_DEF,
	localparam int CPE = (GRID_EDGE + CHUNK_EDGE - 1) / CHUNK_EDGE,
	localparam int CB  = (CPE > 1) ? $clog2(CPE) : 1,
	localparam int LB  = $clog2(CHUNK_EDGE),
	localparam int SB  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
	localparam int DAW = 3 * CB,
	localparam int LAW = 3 * LB,
	localparam int PAW = SB + LAW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         req_type,
	input  logic [BLOCK_W-1:0] block_type,
	input  logic [LIGHT_W-1:0] light_level,
	input  logic               notify,
	output logic               addr_go,
	input  logic               in_grid,
	input  logic [DAW-1:0]     dir_idx,
	input  logic [LAW-1:0]     local_idx,
	output logic               dir_we,
	output logic [DAW-1:0]     dir_addr,
	output logic [SB:0]        dir_wdata,
	input  logic [SB:0]        dir_rdata,
	output logic               pool_we,
	output logic [PAW-1:0]     pool_addr,
	output logic [WORD_W-1:0]  pool_wdata,
	input  logic [WORD_W-1:0]  pool_rdata,
	output logic               done,
	output scvs_result_t       res
);

	localparam int UW = $clog2(POOL_SLOTS + 1);

	scvs_state_t        state_q, state_d;
	logic [DAW-1:0]     dcnt_q;
	logic [LAW-1:0]     zcnt_q;
	logic [UW-1:0]      used_q;
	logic               done_q, done_d;
	scvs_result_t       res_q, res_d;

	scvs_req_t          req_q;
	logic [BLOCK_W-1:0] btype_q;
	logic [LIGHT_W-1:0] lval_q;
	logic               notify_q;
	logic [SB-1:0]      slot_q, slot_d;

	logic               load;
	logic               slot_ld;
	logic               used_inc;
	logic               used_clr;
	logic               have;
	logic               need;
	logic [WORD_W-1:0]  fill_word;
	logic [BLOCK_W-1:0] old_block;
	logic [LIGHT_W-1:0] old_light;

	assign have      = dir_rdata[SB];
	assign need      = ((req_q == REQ_WR_BLOCK) && (btype_q != '0)) ||
		((req_q == REQ_WR_LIGHT) && (lval_q != '0));
	assign fill_word = (req_q == REQ_WR_BLOCK) ? {{LIGHT_W{1'b0}}, btype_q} :
		{lval_q, {BLOCK_W{1'b0}}};
	assign old_block = pool_rdata[BLOCK_W-1:0];
	assign old_light = pool_rdata[WORD_W-1:BLOCK_W];

	always_comb begin
		state_d    = state_q;
		load       = 1'b0;
		slot_ld    = 1'b0;
		slot_d     = slot_q;
		used_inc   = 1'b0;
		used_clr   = 1'b0;
		dir_we     = 1'b0;
		dir_addr   = dir_idx;
		dir_wdata  = '0;
		pool_we    = 1'b0;
		pool_addr  = {slot_q, local_idx};
		pool_wdata = '0;
		done_d     = 1'b0;
		res_d      = '0;
		unique case (state_q)
			S_INIT: begin
				dir_we   = 1'b1;
				dir_addr = dcnt_q;
				if (dcnt_q == '1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					load = 1'b1;
					unique case (scvs_req_t'(req_type))
						REQ_CLEAR: begin
							used_clr = 1'b1;
							state_d  = S_CLEAR;
						end
						REQ_RD_BLOCK, REQ_WR_BLOCK, REQ_RD_LIGHT, REQ_WR_LIGHT: begin
							state_d = S_SPLIT;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_SPLIT: begin
				state_d = S_DIR;
			end
			S_DIR: begin
				if (!in_grid) begin
					done_d       = 1'b1;
					res_d.status = STAT_OUTSIDE;
					state_d      = S_IDLE;
				end else begin
					state_d = S_POOL;
				end
			end
			S_POOL: begin
				pool_addr = {dir_rdata[SB-1:0], local_idx};
				if (have) begin
					slot_ld = 1'b1;
					slot_d  = dir_rdata[SB-1:0];
					state_d = S_MOD;
				end else if (!need) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else if (used_q == UW'(POOL_SLOTS)) begin
					done_d       = 1'b1;
					res_d.status = STAT_FULL;
					state_d      = S_IDLE;
				end else begin
					dir_we    = 1'b1;
					dir_wdata = {1'b1, used_q[SB-1:0]};
					used_inc  = 1'b1;
					slot_ld   = 1'b1;
					slot_d    = used_q[SB-1:0];
					state_d   = S_ZERO;
				end
			end
			S_MOD: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
				unique case (req_q)
					REQ_RD_BLOCK: begin
						res_d.read_value = old_block;
					end
					REQ_RD_LIGHT: begin
						res_d.read_value = {{(BLOCK_W - LIGHT_W){1'b0}}, old_light};
					end
					REQ_WR_BLOCK: begin
						if (old_block != btype_q) begin
							pool_we       = 1'b1;
							pool_wdata    = {old_light, btype_q};
							res_d.removed = notify_q && (old_block != '0);
							res_d.placed  = notify_q && (btype_q != '0);
						end
					end
					REQ_WR_LIGHT: begin
						pool_we    = 1'b1;
						pool_wdata = {lval_q, old_block};
					end
					default: begin
					end
				endcase
			end
			S_ZERO: begin
				pool_we    = 1'b1;
				pool_addr  = {slot_q, zcnt_q};
				pool_wdata = (zcnt_q == local_idx) ? fill_word : '0;
				if (zcnt_q == '1) begin
					done_d       = 1'b1;
					res_d.placed = notify_q && (req_q == REQ_WR_BLOCK);
					state_d      = S_IDLE;
				end
			end
			S_CLEAR: begin
				dir_we   = 1'b1;
				dir_addr = dcnt_q;
				if (dcnt_q == '1) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			dcnt_q  <= '0;
			zcnt_q  <= '0;
			used_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if ((state_q == S_INIT) || (state_q == S_CLEAR)) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (state_q == S_ZERO) begin
				zcnt_q <= zcnt_q + 1'b1;
			end
			if (used_clr) begin
				used_q <= '0;
			end else if (used_inc) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_q    <= scvs_req_t'(req_type);
			btype_q  <= block_type;
			lval_q   <= light_level;
			notify_q <= notify;
		end
		if (slot_ld) begin
			slot_q <= slot_d;
		end
		if (done_d) begin
			res_q <= res_d;
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign addr_go = load;
	assign done    = done_q;
	assign res     = res_q;

endmodule

// File: verif/tb_sparse_chunked_voxel_store_core.sv
`timescale 1ns / 100ps
// Testbench for sparse_chunked_voxel_store_core: directed cases, pool exhaustion, random traffic.
// A predictor keeps its own chunk directory and slot pools; every result transfer is checked against it.
// Depends on scvs_pkg and the core; needs no files or arguments.
module tb_sparse_chunked_voxel_store_core;
	import scvs_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int GRID         = GRID_EDGE_DEF;
	localparam int GRID_LAST    = GRID - 1;
	localparam int CEDGE        = CHUNK_EDGE_DEF;
	localparam int SLOTS        = POOL_SLOTS_DEF;
	localparam int CPE          = (GRID + CEDGE - 1) / CEDGE;
	localparam int CHUNKS       = CPE * CPE * CPE;
	localparam int HALF_Z       = (CEDGE + 1) / 2;
	localparam int SLOT_BLOCKS  = CEDGE * CEDGE * CEDGE;
	localparam int SLOT_LIGHTS  = CEDGE * CEDGE * HALF_Z;
	localparam int HOT_CHUNKS   = 4;
	localparam int SPARE_CHUNK  = 1;
	localparam int DRAIN_CYCLES = 32;
	localparam int CYCLE_LIMIT  = 30_000_000;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      start       = 1'b0;
	logic [2:0]                req_type    = REQ_RD_BLOCK;
	logic signed [COORD_W-1:0] pos_x       = '0;
	logic signed [COORD_W-1:0] pos_y       = '0;
	logic signed [COORD_W-1:0] pos_z       = '0;
	logic [BLOCK_W-1:0]        block_type  = '0;
	logic [LIGHT_W-1:0]        light_level = '0;
	logic                      notify      = 1'b0;
	logic                      busy;
	logic                      done;
	logic [BLOCK_W-1:0]        read_value;
	logic                      removed_event;
	logic                      placed_event;
	logic [1:0]                status;

	bit           chunk_live [CHUNKS];
	int           chunk_slot [CHUNKS];
	logic [7:0]   block_mem [SLOTS * SLOT_BLOCKS];
	logic [7:0]   light_mem [SLOTS * SLOT_LIGHTS];
	int           slots_taken = 0;
	scvs_result_t expected_results [$];

	int sender_idle_pct = 0;
	int cycle_count     = 0;
	int mismatches      = 0;
	int requests_sent   = 0;
	int results_checked = 0;
	int allocations     = 0;
	int full_drops      = 0;
	int outside_hits    = 0;
	int events_raised   = 0;
	int clears          = 0;

	sparse_chunked_voxel_store_core uut (.*);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int chunk_base(input int ci, input int axis);
		case (axis)
			0: return (ci / (CPE * CPE)) * CEDGE;
			1: return ((ci / CPE) % CPE) * CEDGE;
			default: return (ci % CPE) * CEDGE;
		endcase
	endfunction

	function automatic bit claim_slot(input int ci);
		if (slots_taken >= SLOTS)
			return 1'b0;
		for (int i = 0; i < SLOT_BLOCKS; i++)
			block_mem[slots_taken * SLOT_BLOCKS + i] = '0;
		for (int i = 0; i < SLOT_LIGHTS; i++)
			light_mem[slots_taken * SLOT_LIGHTS + i] = '0;
		chunk_live[ci] = 1'b1;
		chunk_slot[ci] = slots_taken;
		slots_taken++;
		allocations++;
		return 1'b1;
	endfunction

	function automatic scvs_result_t predict_access(input logic [2:0] rt,
			input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
			input logic signed [COORD_W-1:0] pz, input logic [BLOCK_W-1:0] bt,
			input logic [LIGHT_W-1:0] lv, input logic nt);
		scvs_result_t r;
		int x, y, z, ci, boff, loff, idx;
		logic [7:0] prior, pk;
		bit odd_z;
		r = '0;
		x = px;
		y = py;
		z = pz;
		if (rt == REQ_CLEAR) begin
			foreach (chunk_live[i])
				chunk_live[i] = 1'b0;
			slots_taken = 0;
			clears++;
			return r;
		end
		if (rt > REQ_CLEAR)
			return r;
		if (x < 0 || x >= GRID || y < 0 || y >= GRID || z < 0 || z >= GRID) begin
			r.status = STAT_OUTSIDE;
			outside_hits++;
			return r;
		end
		ci    = ((x / CEDGE) * CPE + y / CEDGE) * CPE + z / CEDGE;
		boff  = ((x % CEDGE) * CEDGE + y % CEDGE) * CEDGE + z % CEDGE;
		loff  = ((x % CEDGE) * CEDGE + y % CEDGE) * HALF_Z + (z % CEDGE) / 2;
		odd_z = (z % CEDGE) % 2;
		case (rt)
			REQ_RD_BLOCK: begin
				if (chunk_live[ci])
					r.read_value = block_mem[chunk_slot[ci] * SLOT_BLOCKS + boff];
			end
			REQ_RD_LIGHT: begin
				if (chunk_live[ci]) begin
					pk = light_mem[chunk_slot[ci] * SLOT_LIGHTS + loff];
					r.read_value = odd_z ? {4'd0, pk[7:4]} : {4'd0, pk[3:0]};
				end
			end
			REQ_WR_BLOCK: begin
				prior = chunk_live[ci] ? block_mem[chunk_slot[ci] * SLOT_BLOCKS + boff] : 8'd0;
				if (prior != bt) begin
					if (!chunk_live[ci] && !claim_slot(ci)) begin
						r.status = STAT_FULL;
						full_drops++;
					end else begin
						block_mem[chunk_slot[ci] * SLOT_BLOCKS + boff] = bt;
						if (nt) begin
							if (bt == 0) begin
								r.removed = 1'b1;
							end else begin
								r.removed = prior != 0;
								r.placed  = 1'b1;
							end
						end
					end
				end
			end
			default: begin
				if (!chunk_live[ci] && lv == 0) begin
					// An all-zero chunk stays unallocated.
				end else if (!chunk_live[ci] && !claim_slot(ci)) begin
					r.status = STAT_FULL;
					full_drops++;
				end else begin
					idx = chunk_slot[ci] * SLOT_LIGHTS + loff;
					pk  = light_mem[idx];
					if (odd_z)
						pk[7:4] = lv;
					else
						pk[3:0] = lv;
					light_mem[idx] = pk;
				end
			end
		endcase
		events_raised += r.removed + r.placed;
		return r;
	endfunction

	// Returns at the rising edge on which the request transfer took place.
	task automatic send_req(input logic [2:0] rt, input int x, input int y, input int z,
			input logic [BLOCK_W-1:0] bt, input logic [LIGHT_W-1:0] lv, input logic nt);
		logic signed [COORD_W-1:0] px, py, pz;
		bit taken;
		px = COORD_W'(x);
		py = COORD_W'(y);
		pz = COORD_W'(z);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		req_type    <= rt;
		pos_x       <= px;
		pos_y       <= py;
		pos_z       <= pz;
		block_type  <= bt;
		light_level <= lv;
		notify      <= nt;
		do begin
			@(negedge clk);
			taken = (busy === 1'b0);
			@(posedge clk);
		end while (!taken);
		expected_results.push_back(predict_access(rt, px, py, pz, bt, lv, nt));
		requests_sent++;
	endtask

	always @(negedge clk) begin : check_results
		scvs_result_t want;
		if (arst_n && done === 1'b1) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$error("result transfer with no request outstanding");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, read_value);
					mismatches++;
				end
				if (removed_event !== want.removed) begin
					$error("removed_event: expected %0d, got %0d", want.removed, removed_event);
					mismatches++;
				end
				if (placed_event !== want.placed) begin
					$error("placed_event: expected %0d, got %0d", want.placed, placed_event);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
			end
		end
	end

	task automatic test_directed();
		sender_idle_pct = 6;
		send_req(REQ_RD_BLOCK, 0, 0, 0, 8'h00, 4'h0, 1'b1);
		send_req(REQ_WR_LIGHT, 5, 5, 5, 8'h00, 4'h0, 1'b1);
		send_req(REQ_WR_BLOCK, 5, 5, 5, 8'h00, 4'hF, 1'b1);
		send_req(REQ_WR_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'hFF, 4'hF, 1'b1);
		send_req(REQ_RD_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'h00, 4'h0, 1'b0);
		send_req(REQ_WR_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'hFF, 4'h0, 1'b1);
		send_req(REQ_WR_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'h5A, 4'h0, 1'b1);
		send_req(REQ_WR_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'h00, 4'h0, 1'b1);
		send_req(REQ_WR_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'hA5, 4'h0, 1'b0);
		send_req(REQ_WR_LIGHT, GRID_LAST, GRID_LAST, GRID_LAST, 8'hFF, 4'hF, 1'b1);
		send_req(REQ_WR_LIGHT, GRID_LAST, GRID_LAST, GRID_LAST - 1, 8'h00, 4'hA, 1'b1);
		send_req(REQ_RD_LIGHT, GRID_LAST, GRID_LAST, GRID_LAST, 8'h00, 4'h0, 1'b0);
		send_req(REQ_RD_LIGHT, GRID_LAST, GRID_LAST, GRID_LAST - 1, 8'h00, 4'h0, 1'b0);
		send_req(REQ_RD_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'h00, 4'h0, 1'b0);
		send_req(REQ_WR_LIGHT, 0, 0, 1, 8'h00, 4'h5, 1'b1);
		send_req(REQ_RD_BLOCK, 0, 0, 1, 8'h00, 4'h0, 1'b0);
		send_req(REQ_RD_BLOCK, -1, 0, 0, 8'h00, 4'h0, 1'b0);
		send_req(REQ_WR_BLOCK, GRID, 0, 0, 8'h11, 4'h0, 1'b1);
		send_req(REQ_WR_LIGHT, 0, -1024, 0, 8'h00, 4'h3, 1'b1);
		send_req(REQ_RD_LIGHT, 0, 0, 1023, 8'h00, 4'h0, 1'b0);
		for (int k = 1; k <= 3; k++)
			send_req(3'(REQ_CLEAR + k), 0, 0, 0, 8'hFF, 4'hF, 1'b1);
		send_req(REQ_CLEAR, 0, 0, 0, 8'h00, 4'h0, 1'b0);
		send_req(REQ_RD_BLOCK, GRID_LAST, GRID_LAST, GRID_LAST, 8'h00, 4'h0, 1'b0);
	endtask

	task automatic test_pool_exhaustion();
		int ci, fx, fy, fz;
		sender_idle_pct = 6;
		fx = chunk_base(SPARE_CHUNK, 0);
		fy = chunk_base(SPARE_CHUNK, 1);
		fz = chunk_base(SPARE_CHUNK, 2);
		send_req(REQ_CLEAR, 0, 0, 0, 8'h00, 4'h0, 1'b0);
		for (int s = 0; s < SLOTS; s++) begin
			ci = (s * 8 + s % 8) % CHUNKS;
			if (s % 2)
				send_req(REQ_WR_LIGHT, chunk_base(ci, 0) + s % CEDGE, chunk_base(ci, 1),
					chunk_base(ci, 2) + 1, 8'h00, LIGHT_W'($urandom_range(1, 15)), 1'b1);
			else
				send_req(REQ_WR_BLOCK, chunk_base(ci, 0) + s % CEDGE, chunk_base(ci, 1),
					chunk_base(ci, 2), BLOCK_W'($urandom_range(1, 255)), 4'h0, s % 4 == 0);
		end
		send_req(REQ_WR_BLOCK, fx, fy, fz, 8'h42, 4'h0, 1'b1);
		send_req(REQ_WR_LIGHT, fx, fy, fz + 1, 8'h00, 4'h9, 1'b1);
		send_req(REQ_WR_BLOCK, fx, fy, fz, 8'h00, 4'h0, 1'b1);
		send_req(REQ_WR_LIGHT, fx, fy, fz, 8'h00, 4'h0, 1'b1);
		send_req(REQ_RD_BLOCK, fx, fy, fz, 8'h00, 4'h0, 1'b0);
		send_req(REQ_RD_LIGHT, fx, fy, fz + 1, 8'h00, 4'h0, 1'b0);
		send_req(REQ_WR_BLOCK, 1, 1, 1, 8'h7E, 4'h0, 1'b1);
		send_req(REQ_RD_BLOCK, 1, 1, 1, 8'h00, 4'h0, 1'b0);
		send_req(REQ_CLEAR, 0, 0, 0, 8'h00, 4'h0, 1'b0);
		send_req(REQ_WR_BLOCK, fx, fy, fz, 8'h42, 4'h0, 1'b1);
		send_req(REQ_RD_BLOCK, fx, fy, fz, 8'h00, 4'h0, 1'b0);
	endtask

	// Most traffic lands in a few small hot regions so that reads and rewrites
	// meet stored data; the rest is edges, fresh chunks and outside coordinates.
	task automatic test_random_traffic(input int count, input int idle_pct);
		int hot [HOT_CHUNKS];
		int pick, kind, ci, cx, cy, cz, wild;
		logic [2:0] rt;
		logic [BLOCK_W-1:0] bt;
		logic [LIGHT_W-1:0] lv;
		sender_idle_pct = idle_pct;
		foreach (hot[i])
			hot[i] = $urandom_range(0, CHUNKS - 1);
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 999);
			if (pick < 5)
				rt = REQ_CLEAR;
			else if (pick < 20)
				rt = 3'(REQ_CLEAR + $urandom_range(1, 3));
			else if (pick < 270)
				rt = REQ_RD_BLOCK;
			else if (pick < 600)
				rt = REQ_WR_BLOCK;
			else if (pick < 750)
				rt = REQ_RD_LIGHT;
			else
				rt = REQ_WR_LIGHT;
			pick = $urandom_range(0, 99);
			if (pick < 25)
				bt = '0;
			else if (pick < 45)
				bt = BLOCK_W'($urandom_range(1, 3));
			else
				bt = BLOCK_W'($urandom);
			lv = ($urandom_range(0, 4) == 0) ? '0 : LIGHT_W'($urandom);
			cx = $urandom_range(0, GRID_LAST);
			cy = $urandom_range(0, GRID_LAST);
			cz = $urandom_range(0, GRID_LAST);
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				wild = $urandom_range(0, 1) ? -int'($urandom_range(1, 1024))
					: int'($urandom_range(GRID, 1023));
				case ($urandom_range(0, 3))
					0: cx = wild;
					1: cy = wild;
					2: cz = wild;
					default: begin
						cx = int'($urandom_range(0, 2047)) - 1024;
						cy = int'($urandom_range(0, 2047)) - 1024;
						cz = int'($urandom_range(0, 2047)) - 1024;
					end
				endcase
			end else if (kind < 11) begin
				// Any chunk of the grid, usually a fresh one.
			end else if (kind < 16) begin
				pick = $urandom_range(0, 2);
				cx = (pick == 0) ? 0 : (pick == 1) ? GRID_LAST : cx;
				pick = $urandom_range(0, 2);
				cy = (pick == 0) ? 0 : (pick == 1) ? GRID_LAST : cy;
				pick = $urandom_range(0, 2);
				cz = (pick == 0) ? 0 : (pick == 1) ? GRID_LAST : cz;
			end else begin
				ci = hot[$urandom_range(0, HOT_CHUNKS - 1)];
				if ($urandom_range(0, 4) != 0) begin
					cx = chunk_base(ci, 0) + $urandom_range(0, 1);
					cy = chunk_base(ci, 1) + $urandom_range(0, 1);
					cz = chunk_base(ci, 2) + $urandom_range(0, 3);
				end else begin
					cx = chunk_base(ci, 0) + $urandom_range(0, CEDGE - 1);
					cy = chunk_base(ci, 1) + $urandom_range(0, CEDGE - 1);
					cz = chunk_base(ci, 2) + $urandom_range(0, CEDGE - 1);
				end
			end
			send_req(rt, cx, cy, cz, bt, lv, $urandom_range(0, 3) != 0);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_exhaustion();
		test_random_traffic(450, 6);
		test_random_traffic(450, 48);
		test_random_traffic(450, 0);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d requests with %0d results checked, %0d world clears.",
			requests_sent, results_checked, clears);
		$display("Saw %0d chunk allocations, %0d pool-full drops, %0d outside, %0d events.",
			allocations, full_drops, outside_hits, events_raised);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
design/scvs_pkg.sv
design/scvs_ram.sv
design/scvs_addr.sv
design/scvs_ctrl.sv
design/sparse_chunked_voxel_store_core.sv
verif/tb_sparse_chunked_voxel_store_core.sv
